// ----- rtl/bti_pkg.sv -----
// ----------------------------------------------------------------------------
// bti_pkg: shared types and constants
// Item codes, register map and field widths of the bilinear table interpolator.
// ----------------------------------------------------------------------------
package bti_pkg;

  typedef enum logic [1:0] {
    OP_QUERY    = 2'd0,
    OP_SPEED_BP = 2'd1,
    OP_ANGLE_BP = 2'd2,
    OP_CELL     = 2'd3
  } op_t;

  localparam int VAL_W   = 16;  // Q8.8 values
  localparam int FRAC_W  = 17;  // Q1.16 fraction, 65536 is 1.0
  localparam int ANGLE_W = 17;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 4;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [PADDR_W-1:0] REG_SPEED_COUNT = 4'h0;
  localparam logic [PADDR_W-1:0] REG_ANGLE_COUNT = 4'h4;
  localparam logic [PADDR_W-1:0] REG_TABLE_READY = 4'h8;

  localparam logic [4:0] SPEED_COUNT_RST = 5'd2;
  localparam logic [5:0] ANGLE_COUNT_RST = 6'd2;

endpackage

// ----- rtl/bti_if.sv -----
// ----------------------------------------------------------------------------
// bti_if: word channels
// Valid/ready channels for query/write words and for result words.
// ----------------------------------------------------------------------------
interface bti_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [4:0]         row_index;
  logic [3:0]         column_index;
  logic [15:0]        write_value;
  logic [15:0]        query_speed;
  logic signed [16:0] query_angle;

  modport source (output valid, operation, row_index, column_index, write_value,
                  query_speed, query_angle, input ready);
  modport sink   (input valid, operation, row_index, column_index, write_value,
                  query_speed, query_angle, output ready);
endinterface

interface bti_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] target_speed;
  logic        not_ready;

  modport source (output valid, target_speed, not_ready, input ready);
  modport sink   (input valid, target_speed, not_ready, output ready);
endinterface

// ----- rtl/bti_locate.sv -----
// ----------------------------------------------------------------------------
// bti_locate: breakpoint store, interval search and fraction divider
// Clamp, search, bound fetch, then a 16-stage restoring divider. 19 stages.
// ----------------------------------------------------------------------------
module bti_locate
  import bti_pkg::*;
#(
  parameter int N = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          bp_we,
  input  logic [((N > 1) ? $clog2(N) : 1)-1:0] bp_waddr,
  input  logic [VAL_W-1:0]              bp_wdata,
  input  logic [$clog2(N+1)-1:0]        n,
  input  logic [ANGLE_W-1:0]            x,
  output logic [((N > 1) ? $clog2(N) : 1)-1:0] idx,
  output logic [FRAC_W-1:0]             frac
);

  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam int NW = $clog2(N+1);
  localparam int DIV_STEPS = 16;

  logic [VAL_W-1:0] bp_r [N];

  always_ff @(posedge clk) begin
    if (bp_we) begin
      bp_r[bp_waddr] <= bp_wdata;
    end
  end

  // stage a: clamp, low bound first
  logic [VAL_W-1:0] lo, hi, xc;
  logic [VAL_W-1:0] xa_r;
  logic [NW-1:0]    na_r;

  always_comb begin
    lo = bp_r[0];
    hi = bp_r[IW'(n - 1'b1)];
    if (x < {1'b0, lo}) begin
      xc = lo;
    end else if (x > {1'b0, hi}) begin
      xc = hi;
    end else begin
      xc = x[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa_r <= xc;
      na_r <= n;
    end
  end

  // stage b: last breakpoint at or below x, stop at first above, capped at n-2
  logic [IW-1:0]    kk;
  logic             found;
  logic [IW-1:0]    kb_r;
  logic [VAL_W-1:0] xb_r;

  always_comb begin
    found = 1'b0;
    kk    = '0;
    for (int i = 0; i < N; i++) begin
      if (!found && i < int'(na_r)) begin
        if (bp_r[i] <= xa_r) begin
          kk = IW'(i);
        end else begin
          found = 1'b1;
        end
      end
    end
    if (int'(kk) > int'(na_r) - 2) begin
      kk = IW'(int'(na_r) - 2);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kb_r <= kk;
      xb_r <= xa_r;
    end
  end

  // stage c: interval bounds, divider setup
  logic [VAL_W-1:0] b0, b1, diff, dd;
  logic             live;

  always_comb begin
    b0   = bp_r[kb_r];
    b1   = bp_r[IW'(kb_r + 1'b1)];
    live = (b1 > b0) && (xb_r > b0);
    diff = xb_r - b0;
    dd   = b1 - b0;
  end

  logic [VAL_W-1:0] rem_r  [DIV_STEPS+1];
  logic [VAL_W-1:0] d_r    [DIV_STEPS+1];
  logic [15:0]      q_r    [DIV_STEPS+1];
  logic             sat_r  [DIV_STEPS+1];
  logic             zero_r [DIV_STEPS+1];
  logic [IW-1:0]    k_r    [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= diff;
      d_r[0]    <= dd;
      q_r[0]    <= '0;
      sat_r[0]  <= live && (diff >= dd);
      zero_r[0] <= !live;
      k_r[0]    <= kb_r;
    end
  end

  // one quotient bit per stage; remainder stays below the divisor while the dividend starts below it
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [VAL_W:0] r2;
    logic           ge;

    always_comb begin
      r2 = {rem_r[j-1], 1'b0};
      ge = (r2 >= {1'b0, d_r[j-1]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= ge ? VAL_W'(r2 - {1'b0, d_r[j-1]}) : r2[VAL_W-1:0];
        d_r[j]    <= d_r[j-1];
        q_r[j]    <= {q_r[j-1][14:0], ge};
        sat_r[j]  <= sat_r[j-1];
        zero_r[j] <= zero_r[j-1];
        k_r[j]    <= k_r[j-1];
      end
    end
  end

  always_comb begin
    idx = k_r[DIV_STEPS];
    if (zero_r[DIV_STEPS]) begin
      frac = '0;
    end else if (sat_r[DIV_STEPS]) begin
      frac = FRAC_W'(17'h10000);
    end else begin
      frac = {1'b0, q_r[DIV_STEPS]};
    end
  end

endmodule

// ----- rtl/bti_cell_mem.sv -----
// ----------------------------------------------------------------------------
// bti_cell_mem: cell store in four banks
// Banked by row and column parity so the four corners are read in parallel.
// ----------------------------------------------------------------------------
module bti_cell_mem
  import bti_pkg::*;
#(
  parameter int MAX_SPEEDS = 16,
  parameter int MAX_ANGLES = 32
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [((MAX_ANGLES > 1) ? $clog2(MAX_ANGLES) : 1)-1:0] wrow,
  input  logic [((MAX_SPEEDS > 1) ? $clog2(MAX_SPEEDS) : 1)-1:0] wcol,
  input  logic [VAL_W-1:0]          wdata,
  input  logic                      re,
  input  logic [((MAX_ANGLES > 1) ? $clog2(MAX_ANGLES) : 1)-1:0] row,
  input  logic [((MAX_SPEEDS > 1) ? $clog2(MAX_SPEEDS) : 1)-1:0] col,
  output logic [VAL_W-1:0]          c00,
  output logic [VAL_W-1:0]          c01,
  output logic [VAL_W-1:0]          c10,
  output logic [VAL_W-1:0]          c11
);

  localparam int RW = (MAX_ANGLES > 1) ? $clog2(MAX_ANGLES) : 1;
  localparam int CW = (MAX_SPEEDS > 1) ? $clog2(MAX_SPEEDS) : 1;
  localparam int HA = (MAX_ANGLES + 1) / 2;
  localparam int HS = (MAX_SPEEDS + 1) / 2;
  localparam int BD = HA * HS;
  localparam int AW = (BD > 1) ? $clog2(BD) : 1;

  logic [VAL_W-1:0] rd [2][2];
  logic             rp_r, cp_r;

  for (genvar rp = 0; rp < 2; rp++) begin : g_row
    for (genvar cp = 0; cp < 2; cp++) begin : g_col
      logic [VAL_W-1:0] mem [BD];
      logic [RW-1:0]    r;
      logic [CW-1:0]    c;
      logic [AW-1:0]    raddr, waddr;
      logic             wsel;

      always_comb begin
        r     = (row[0] == 1'(rp)) ? row : RW'(row + 1'b1);
        c     = (col[0] == 1'(cp)) ? col : CW'(col + 1'b1);
        raddr = AW'(int'(r >> 1) * HS + int'(c >> 1));
        waddr = AW'(int'(wrow >> 1) * HS + int'(wcol >> 1));
        wsel  = we && (wrow[0] == 1'(rp)) && (wcol[0] == 1'(cp));
      end

      always_ff @(posedge clk) begin
        if (wsel) begin
          mem[waddr] <= wdata;
        end
        if (re) begin
          rd[rp][cp] <= mem[raddr];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rp_r <= row[0];
      cp_r <= col[0];
    end
  end

  assign c00 = rd[rp_r][cp_r];
  assign c01 = rd[rp_r][!cp_r];
  assign c10 = rd[!rp_r][cp_r];
  assign c11 = rd[!rp_r][!cp_r];

endmodule

// ----- rtl/bti_blend.sv -----
// ----------------------------------------------------------------------------
// bti_blend: two-level linear blend
// Speed blends of both rows registered, then the angle blend.
// ----------------------------------------------------------------------------
module bti_blend
  import bti_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [VAL_W-1:0]  c00,
  input  logic [VAL_W-1:0]  c01,
  input  logic [VAL_W-1:0]  c10,
  input  logic [VAL_W-1:0]  c11,
  input  logic [FRAC_W-1:0] ft,
  input  logic [FRAC_W-1:0] fa,
  output logic [VAL_W-1:0]  value
);

  // floor(a + (b - a) * t / 65536), always between a and b
  function automatic logic [VAL_W-1:0] lerp(input logic [VAL_W-1:0] a,
                                            input logic [VAL_W-1:0] b,
                                            input logic [FRAC_W-1:0] t);
    logic signed [VAL_W:0]  df;
    logic signed [35:0]     s;
    df = $signed({1'b0, b}) - $signed({1'b0, a});
    s  = $signed({4'b0, a, 16'b0}) + 36'(df * $signed({1'b0, t}));
    return s[31:16];
  endfunction

  logic [VAL_W-1:0]  r0_r, r1_r;
  logic [FRAC_W-1:0] fa_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r0_r <= lerp(c00, c01, ft);
      r1_r <= lerp(c10, c11, ft);
      fa_r <= fa;
    end
  end

  assign value = lerp(r0_r, r1_r, fa_r);

endmodule

// ----- rtl/bilinear_table_interpolator.sv -----
// ----------------------------------------------------------------------------
// bilinear_table_interpolator: 2-D table lookup with bilinear blend
// Non-uniform speed/angle grid, query and table-write words, APB registers.
// ----------------------------------------------------------------------------
// Usage:
//   in_word carries query words (operation query) and table-write words
//   (speed breakpoint, angle breakpoint, cell). Writes give no result word;
//   each query gives one result word on out_word.
//   Registers over APB: speed_count @0x0, angle_count @0x4, table_ready @0x8.
//   Program them only while no query is in flight.
// Throughput: one query word per cycle while the output does not stall. The
//   pipe is angle magnitude, clamp, search, bound fetch, a 16-stage fraction
//   divider, banked cell read, two blends and the output register.
// A write word is held off until no query is in flight, so it never
//   races a query that reads the table; back-to-back writes are taken one per cycle.
// Reset (rst_n low, synchronous): pipe emptied, speed_count and angle_count
//   return to 2, table_ready to 0. Table contents are not cleared.
// A query with table_ready low returns not_ready = 1 and target_speed = 0.
// Out stall: while the result word waits on out_word.ready the whole pipe
//   holds and in_word.ready is low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module bilinear_table_interpolator
  import bti_pkg::*;
#(
  parameter int MAX_SPEEDS = 16,
  parameter int MAX_ANGLES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  bti_in_if.sink             in_word,
  bti_out_if.source          out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int SIW = (MAX_SPEEDS > 1) ? $clog2(MAX_SPEEDS) : 1;
  localparam int AIW = (MAX_ANGLES > 1) ? $clog2(MAX_ANGLES) : 1;
  localparam int SNW = $clog2(MAX_SPEEDS + 1);
  localparam int ANW = $clog2(MAX_ANGLES + 1);
  localparam int LOC_LAT = 19;          // locate stages after the entry stage
  localparam int MEM_ST  = LOC_LAT + 1; // cell read register
  localparam int OUT_ST  = MEM_ST + 2;  // output register
  localparam int DEPTH   = OUT_ST + 1;

  // ---------------- configuration registers ----------------
  logic [4:0] speed_count_r;
  logic [5:0] angle_count_r;
  logic       table_ready_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_count_r <= SPEED_COUNT_RST;
      angle_count_r <= ANGLE_COUNT_RST;
      table_ready_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr)
        REG_SPEED_COUNT: speed_count_r <= pwdata[4:0];
        REG_ANGLE_COUNT: angle_count_r <= pwdata[5:0];
        REG_TABLE_READY: table_ready_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_SPEED_COUNT: prdata = {27'b0, speed_count_r};
      REG_ANGLE_COUNT: prdata = {26'b0, angle_count_r};
      REG_TABLE_READY: prdata = {31'b0, table_ready_r};
      default:         prdata = '0;
    endcase
  end

  // counts in use, held to 2..max
  logic [SNW-1:0] ns;
  logic [ANW-1:0] na;

  always_comb begin
    if (int'(speed_count_r) < 2) begin
      ns = SNW'(2);
    end else if (int'(speed_count_r) > MAX_SPEEDS) begin
      ns = SNW'(MAX_SPEEDS);
    end else begin
      ns = SNW'(speed_count_r);
    end
    if (int'(angle_count_r) < 2) begin
      na = ANW'(2);
    end else if (int'(angle_count_r) > MAX_ANGLES) begin
      na = ANW'(MAX_ANGLES);
    end else begin
      na = ANW'(angle_count_r);
    end
  end

  // ---------------- pipe control ----------------
  logic [DEPTH-1:0] v_r;    // valid per stage
  logic [DEPTH-1:0] nr_r;   // not-ready flag per stage
  logic             adv;
  logic             busy;
  logic             is_query;
  logic             acc;
  logic             acc_query;
  logic             acc_write;

  assign adv       = !v_r[OUT_ST] || out_word.ready;
  assign busy      = |v_r;
  assign is_query  = (op_t'(in_word.operation) == OP_QUERY);
  assign in_word.ready = adv && (is_query || !busy);
  assign acc       = in_word.valid && in_word.ready;
  assign acc_query = acc && is_query;
  assign acc_write = acc && !is_query;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[DEPTH-2:0], acc_query};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nr_r <= {nr_r[DEPTH-2:0], !table_ready_r};
    end
  end

  // ---------------- table writes ----------------
  logic sp_we, an_we, cell_we;
  logic row_ok, col_ok;

  assign row_ok  = int'(in_word.row_index) < MAX_ANGLES;
  assign col_ok  = int'(in_word.column_index) < MAX_SPEEDS;
  assign sp_we   = acc_write && (op_t'(in_word.operation) == OP_SPEED_BP) && col_ok;
  assign an_we   = acc_write && (op_t'(in_word.operation) == OP_ANGLE_BP) && row_ok;
  assign cell_we = acc_write && (op_t'(in_word.operation) == OP_CELL) && row_ok && col_ok;

  // ---------------- entry stage: speed and angle magnitude ----------------
  logic [ANGLE_W-1:0] qs_r, mag_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      qs_r  <= {1'b0, in_word.query_speed};
      mag_r <= in_word.query_angle[16] ? ANGLE_W'(~in_word.query_angle + 1'b1)
                                       : ANGLE_W'(in_word.query_angle);
    end
  end

  // ---------------- locate both axes ----------------
  logic [SIW-1:0]    ti;
  logic [AIW-1:0]    ai;
  logic [FRAC_W-1:0] ft, fa;

  bti_locate #(.N(MAX_SPEEDS)) u_loc_speed (
    .clk      (clk),
    .en       (adv),
    .bp_we    (sp_we),
    .bp_waddr (SIW'(in_word.column_index)),
    .bp_wdata (in_word.write_value),
    .n        (ns),
    .x        (qs_r),
    .idx      (ti),
    .frac     (ft)
  );

  bti_locate #(.N(MAX_ANGLES)) u_loc_angle (
    .clk      (clk),
    .en       (adv),
    .bp_we    (an_we),
    .bp_waddr (AIW'(in_word.row_index)),
    .bp_wdata (in_word.write_value),
    .n        (na),
    .x        (mag_r),
    .idx      (ai),
    .frac     (fa)
  );

  // ---------------- corner read ----------------
  logic [VAL_W-1:0]  c00, c01, c10, c11;
  logic [FRAC_W-1:0] ft_r, fa_r;

  bti_cell_mem #(.MAX_SPEEDS(MAX_SPEEDS), .MAX_ANGLES(MAX_ANGLES)) u_cells (
    .clk   (clk),
    .we    (cell_we),
    .wrow  (AIW'(in_word.row_index)),
    .wcol  (SIW'(in_word.column_index)),
    .wdata (in_word.write_value),
    .re    (adv),
    .row   (ai),
    .col   (ti),
    .c00   (c00),
    .c01   (c01),
    .c10   (c10),
    .c11   (c11)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      ft_r <= ft;
      fa_r <= fa;
    end
  end

  // ---------------- blend and output register ----------------
  logic [VAL_W-1:0] blend_val;
  logic [VAL_W-1:0] target_r;

  bti_blend u_blend (
    .clk   (clk),
    .en    (adv),
    .c00   (c00),
    .c01   (c01),
    .c10   (c10),
    .c11   (c11),
    .ft    (ft_r),
    .fa    (fa_r),
    .value (blend_val)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      target_r <= nr_r[OUT_ST-1] ? '0 : blend_val;
    end
  end

  assign out_word.valid        = v_r[OUT_ST];
  assign out_word.target_speed = target_r;
  assign out_word.not_ready    = nr_r[OUT_ST];

endmodule

// ----- rtl/bti_checker.sv -----
// ----------------------------------------------------------------------------
// bti_checker: port-level checks
// Watches the word channels of the interpolator; bound to the top level.
// ----------------------------------------------------------------------------
module bti_checker
  import bti_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_target_speed,
  input logic        out_not_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_nr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_not_ready |-> out_target_speed == 16'd0)
    else $error("not_ready result with nonzero target");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word after reset");

  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (op_t'(in_operation) != OP_QUERY) |-> !out_valid)
    else $error("table write taken with a query in flight");

  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("word taken while output stalled");

endmodule

bind bilinear_table_interpolator bti_checker u_bti_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_word.valid),
  .in_ready         (in_word.ready),
  .in_operation     (in_word.operation),
  .out_valid        (out_word.valid),
  .out_ready        (out_word.ready),
  .out_target_speed (out_word.target_speed),
  .out_not_ready    (out_word.not_ready)
);
